>>> hdl/lpwd_pkg.sv
package lpwd_pkg;

  // Parser phases
  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_EXTRA   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_ERROR   = 2'd3;

  // Result kinds (out_tuser)
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic ERR_TOO_LONG  = 1'b0;
  localparam logic ERR_TOO_MANY  = 1'b1;

  // Config register indexes
  localparam logic REG_MAX_WORD_LEN = 1'b0;
  localparam logic REG_MAX_WORDS    = 1'b1;

  localparam logic [15:0] MAX_WORD_LEN_RST = 16'd1024;
  localparam logic [7:0]  MAX_WORDS_RST    = 8'd64;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_DATA_W  = 16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic [7:0] word_index;
    logic       last_in_word;
    logic [7:0] word_total;
    logic       error_code;
  } res_t;

endpackage

>>> hdl/length_prefixed_word_deframer.sv
// Channel | ports  | tdata (low bit up)                              | tuser     | tlast
// in      | in_t*  | data_byte[7:0]                                  | restart   | -
// out     | out_t* | payload, word_index, word_total, error_code, 0s | kind[1:0] | last_in_word
// cfg     | cfg_*  | index 0 max_word_len, index 1 max_words         | -         | -
//
// One byte per cycle: each byte is decoded in one pass from the parser registers
// into the result register, and the result is valid in the cycle after the input transfer.
// Restart and error-phase bytes give no result; a prefix byte gives at most END or ERROR.
// Input stalls only while a held result is not taken (in_tready = !valid || out_tready).
// Reset (rst_n low, synchronous) clears the parser, drops out_tvalid and loads
// max_word_len = 1024, max_words = 64.
module length_prefixed_word_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write port
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [lpwd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lpwd_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_byte[7:0]
  input  logic                               in_tuser,   // restart
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lpwd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // payload[7:0], word_index[15:8],
                                                         // word_total[23:16], error_code[24]
  output logic [1:0]                         out_tuser,  // kind[1:0]
  output logic                               out_tlast   // last_in_word
);

  // config registers
  logic [15:0] max_word_len_r;
  logic [7:0]  max_words_r;

  // parser state
  logic [1:0]  phase_r,        phase_nxt;
  logic [2:0]  prefix_left_r,  prefix_left_nxt;
  logic [31:0] length_acc_r,   length_acc_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;
  logic [7:0]  word_count_r,   word_count_nxt;

  // result register
  logic             out_valid_r;
  lpwd_pkg::res_t   res_r, res_nxt;
  logic             res_vld;

  logic        in_xfer;
  logic [7:0]  b;
  logic        len_done;
  logic [31:0] len_val;
  logic        pay_last;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign b         = in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_word_len_r <= lpwd_pkg::MAX_WORD_LEN_RST;
      max_words_r    <= lpwd_pkg::MAX_WORDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lpwd_pkg::REG_MAX_WORD_LEN: max_word_len_r <= cfg_wdata;
        lpwd_pkg::REG_MAX_WORDS:    max_words_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Next parser state and result for the byte at the input
  always_comb begin
    phase_nxt        = phase_r;
    prefix_left_nxt  = prefix_left_r;
    length_acc_nxt   = length_acc_r;
    payload_left_nxt = payload_left_r;
    word_count_nxt   = word_count_r;
    res_nxt          = '0;
    res_vld          = 1'b0;
    len_done         = 1'b0;
    len_val          = {length_acc_r[23:0], b};
    pay_last         = (payload_left_r <= 16'd1);

    if (in_tuser) begin
      phase_nxt        = lpwd_pkg::PH_FIRST;
      prefix_left_nxt  = '0;
      length_acc_nxt   = '0;
      payload_left_nxt = '0;
      word_count_nxt   = '0;
    end else begin
      unique case (phase_r)
        lpwd_pkg::PH_FIRST: begin
          if (!b[7]) begin
            len_val  = {24'd0, b};
            len_done = 1'b1;
          end else begin
            phase_nxt = lpwd_pkg::PH_EXTRA;
            if (b[6] == 1'b0) begin
              length_acc_nxt  = {26'd0, b[5:0]};
              prefix_left_nxt = 3'd1;
            end else if (b[5] == 1'b0) begin
              length_acc_nxt  = {27'd0, b[4:0]};
              prefix_left_nxt = 3'd2;
            end else if (b[4] == 1'b0) begin
              length_acc_nxt  = {28'd0, b[3:0]};
              prefix_left_nxt = 3'd3;
            end else begin
              // 1111xxxx: low bits dropped, four length bytes follow
              length_acc_nxt  = '0;
              prefix_left_nxt = 3'd4;
            end
          end
        end
        lpwd_pkg::PH_EXTRA: begin
          length_acc_nxt  = len_val;
          prefix_left_nxt = prefix_left_r - 3'd1;
          len_done        = (prefix_left_r == 3'd1);
        end
        lpwd_pkg::PH_PAYLOAD: begin
          res_vld              = 1'b1;
          res_nxt.kind         = lpwd_pkg::KIND_PAYLOAD;
          res_nxt.payload      = b;
          res_nxt.word_index   = word_count_r;
          res_nxt.last_in_word = pay_last;
          if (pay_last) begin
            payload_left_nxt = '0;
            word_count_nxt   = word_count_r + 8'd1;
            phase_nxt        = lpwd_pkg::PH_FIRST;
          end else begin
            payload_left_nxt = payload_left_r - 16'd1;
          end
        end
        lpwd_pkg::PH_ERROR: ;
        default: ;
      endcase

      // length fully assembled
      if (len_done) begin
        length_acc_nxt = len_val;
        if (len_val == 32'd0) begin
          res_vld            = 1'b1;
          res_nxt.kind       = lpwd_pkg::KIND_END;
          res_nxt.word_total = word_count_r;
          phase_nxt          = lpwd_pkg::PH_FIRST;
          prefix_left_nxt    = '0;
          length_acc_nxt     = '0;
          payload_left_nxt   = '0;
          word_count_nxt     = '0;
        end else if (word_count_r >= max_words_r) begin
          // too many words wins over too long
          res_vld            = 1'b1;
          res_nxt.kind       = lpwd_pkg::KIND_ERROR;
          res_nxt.error_code = lpwd_pkg::ERR_TOO_MANY;
          phase_nxt          = lpwd_pkg::PH_ERROR;
        end else if (len_val >= {16'd0, max_word_len_r}) begin
          res_vld            = 1'b1;
          res_nxt.kind       = lpwd_pkg::KIND_ERROR;
          res_nxt.error_code = lpwd_pkg::ERR_TOO_LONG;
          phase_nxt          = lpwd_pkg::PH_ERROR;
        end else begin
          payload_left_nxt = len_val[15:0];
          phase_nxt        = lpwd_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= lpwd_pkg::PH_FIRST;
      prefix_left_r  <= '0;
      length_acc_r   <= '0;
      payload_left_r <= '0;
      word_count_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r        <= phase_nxt;
        prefix_left_r  <= prefix_left_nxt;
        length_acc_r   <= length_acc_nxt;
        payload_left_r <= payload_left_nxt;
        word_count_r   <= word_count_nxt;
        out_valid_r    <= res_vld;
      end else if (out_tready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a new result is produced
  always_ff @(posedge clk) begin
    if (in_xfer && res_vld) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.error_code, res_r.word_total,
                       res_r.word_index, res_r.payload};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last_in_word;

endmodule

>>> hdl/lpwd_checker.sv
module lpwd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lpwd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [1:0]                        out_tuser,
  input logic                              out_tlast
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // only the defined kinds leave the block
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == lpwd_pkg::KIND_PAYLOAD || out_tuser == lpwd_pkg::KIND_END
      || out_tuser == lpwd_pkg::KIND_ERROR))
    else $error("illegal result kind");

  // only payload results carry byte, index and last flag; on others padding stays zero too
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != lpwd_pkg::KIND_PAYLOAD
      |-> out_tdata[15:0] == 16'd0 && !out_tlast && out_tdata[31:25] == 7'd0)
    else $error("stray fields on non-payload result");

endmodule

bind length_prefixed_word_deframer lpwd_checker u_lpwd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
